// ===== src/sbii_pkg.sv =====
// Shared types, sizes and helpers for the sorted block interval index.
// Used by sbii_front, sbii_back and sorted_block_interval_index.
package sbii_pkg;

  localparam int MAX_BLOCKS  = 64;
  localparam int MAX_CONTIGS = 256;
  localparam int POS_BITS    = 32;
  localparam int RESULT_CAP  = 64;

  localparam int CONTIG_W    = 8;
  localparam int OUT_IDX_W   = 6;
  localparam int IDX_W       = $clog2(MAX_BLOCKS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int NCAP_W      = $clog2(RESULT_CAP + 1);
  // contig ids are 8 bits wide, so no more than 256 range slots are ever addressed
  localparam int RANGE_DEPTH = (MAX_CONTIGS < 256) ? MAX_CONTIGS : 256;
  localparam int SLOT_W      = $clog2(RANGE_DEPTH);
  localparam int RECIP       = (65536 + MAX_CONTIGS - 1) / MAX_CONTIGS;

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [CONTIG_W-1:0] contig_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [NCAP_W-1:0]   ncap_t;
  typedef logic [POS_BITS-1:0] pos_t;

  typedef struct packed {
    logic    is_query;
    contig_t contig;
    slot_t   slot;
    pos_t    lo;
    pos_t    hi;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  // contig id folded onto the range table; for fewer than 256 slots the
  // quotient comes from a ceiling reciprocal, exact for 8-bit ids
  function automatic slot_t fold_slot(contig_t c);
    logic [24:0] prod;
    logic [8:0]  q;
    logic [16:0] qm;
    logic [16:0] rem;
    prod = 25'(c) * 25'(RECIP);
    q    = prod[24:16];
    qm   = 17'(q) * 17'(MAX_CONTIGS);
    rem  = 17'(c) - qm;
    if (MAX_CONTIGS >= 256) begin
      return slot_t'(c);
    end
    return slot_t'(rem);
  endfunction

endpackage

// ===== src/sbii_front.sv =====
// Front end: takes request words, classifies them and queues them.
// Depends on sbii_pkg.
module sbii_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type,
  input  sbii_pkg::contig_t        contig_id,
  input  logic [31:0]              span_low,
  input  logic [31:0]              span_high,
  output sbii_pkg::queue_head_t    head,
  input  logic                     pop
);

  sbii_pkg::cmd_t fifo [sbii_pkg::QDEPTH];
  logic [sbii_pkg::QPTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [sbii_pkg::QPTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [sbii_pkg::QPTR_W:0]   count, count_next;
  logic                        push;
  sbii_pkg::cmd_t              cmd_in;

  assign busy = (count == (sbii_pkg::QPTR_W+1)'(sbii_pkg::QDEPTH));
  assign push = start && !busy;

  always_comb begin
    cmd_in.is_query = (req_type == sbii_pkg::REQ_QUERY);
    cmd_in.contig   = contig_id;
    cmd_in.slot     = sbii_pkg::fold_slot(contig_id);
    cmd_in.lo       = sbii_pkg::pos_t'(span_low);
    cmd_in.hi       = sbii_pkg::pos_t'(span_high);
  end

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = fifo[rd_ptr];

endmodule

// ===== src/sbii_back.sv =====
// Back end: block table, per-contig range table, load and overlap walk.
// Depends on sbii_pkg; fed by sbii_front through a queue_head_t.
module sbii_back (
  input  logic                  clk,
  input  logic                  rst,
  input  sbii_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  result_valid,
  output logic [5:0]            block_index,
  output logic                  hit,
  output logic                  table_full,
  output logic                  last
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RANGE = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // memories
  sbii_pkg::pos_t blk_lo [sbii_pkg::MAX_BLOCKS];
  sbii_pkg::pos_t blk_hi [sbii_pkg::MAX_BLOCKS];
  sbii_pkg::idx_t rs_mem [sbii_pkg::RANGE_DEPTH];
  sbii_pkg::cnt_t re_mem [sbii_pkg::RANGE_DEPTH];

  sbii_pkg::pos_t blk_lo_q, blk_hi_q;
  sbii_pkg::idx_t rs_q;
  sbii_pkg::cnt_t re_q;
  logic           rv_q;
  sbii_pkg::idx_t blk_raddr;

  // control state
  sbii_pkg::cnt_t                   block_count, block_count_next;
  sbii_pkg::contig_t                prev_contig, prev_contig_next;
  logic [sbii_pkg::RANGE_DEPTH-1:0] range_valid, range_valid_next;
  logic                             result_valid_next;
  logic                             pend_valid, pend_valid_next;

  // payload
  sbii_pkg::idx_t out_idx, out_idx_next;
  logic           out_hit, out_hit_next;
  logic           out_full, out_full_next;
  logic           out_last, out_last_next;
  sbii_pkg::pos_t q_lo, q_lo_next;
  sbii_pkg::pos_t q_hi, q_hi_next;
  sbii_pkg::idx_t cur, cur_next;
  sbii_pkg::cnt_t end_q, end_q_next;
  sbii_pkg::ncap_t n_hits, n_hits_next;
  sbii_pkg::idx_t pend_idx, pend_idx_next;

  logic           is_load, full, wr_blk, new_run;
  logic           overlap, stop, cap_hit;
  sbii_pkg::cnt_t cur_inc;

  assign pop     = (state == ST_IDLE) && head.valid;
  assign is_load = pop && !head.cmd.is_query;
  assign full    = (block_count == sbii_pkg::cnt_t'(sbii_pkg::MAX_BLOCKS));
  assign wr_blk  = is_load && !full;
  assign new_run = (block_count == '0) || (head.cmd.contig != prev_contig);

  assign cur_inc = sbii_pkg::cnt_t'(cur) + 1'b1;
  assign overlap = (q_lo >= blk_lo_q && q_lo <= blk_hi_q) ||
                   (q_hi >= blk_lo_q && q_hi <= blk_hi_q) ||
                   (q_lo <= blk_lo_q && q_hi >= blk_hi_q);
  assign cap_hit = overlap &&
                   ((n_hits + 1'b1) == sbii_pkg::ncap_t'(sbii_pkg::RESULT_CAP));
  // sorted by min: once a block starts past the interval nothing later can hit
  assign stop    = (blk_lo_q > q_hi) || (cur_inc >= end_q) || cap_hit;

  assign blk_raddr = (state == ST_RANGE) ? rs_q : sbii_pkg::idx_t'(cur_inc);

  always_ff @(posedge clk) begin
    if (wr_blk) begin
      blk_lo[block_count[sbii_pkg::IDX_W-1:0]] <= head.cmd.lo;
      blk_hi[block_count[sbii_pkg::IDX_W-1:0]] <= head.cmd.hi;
    end
    blk_lo_q <= blk_lo[blk_raddr];
    blk_hi_q <= blk_hi[blk_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_blk) begin
      if (new_run) begin
        rs_mem[head.cmd.slot] <= block_count[sbii_pkg::IDX_W-1:0];
      end
      re_mem[head.cmd.slot] <= block_count + 1'b1;
    end
    if (pop) begin
      rs_q <= rs_mem[head.cmd.slot];
      re_q <= re_mem[head.cmd.slot];
      rv_q <= range_valid[head.cmd.slot];
    end
  end

  always_comb begin
    state_next        = state;
    block_count_next  = block_count;
    prev_contig_next  = prev_contig;
    range_valid_next  = range_valid;
    result_valid_next = 1'b0;
    pend_valid_next   = pend_valid;
    out_idx_next      = '0;
    out_hit_next      = 1'b0;
    out_full_next     = 1'b0;
    out_last_next     = 1'b0;
    q_lo_next         = q_lo;
    q_hi_next         = q_hi;
    cur_next          = cur;
    end_q_next        = end_q;
    n_hits_next       = n_hits;
    pend_idx_next     = pend_idx;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          if (!head.cmd.is_query) begin
            result_valid_next = 1'b1;
            out_last_next     = 1'b1;
            if (full) begin
              out_full_next = 1'b1;
            end else begin
              out_idx_next                  = block_count[sbii_pkg::IDX_W-1:0];
              out_hit_next                  = 1'b1;
              block_count_next              = block_count + 1'b1;
              prev_contig_next              = head.cmd.contig;
              range_valid_next[head.cmd.slot] = 1'b1;
            end
          end else begin
            q_lo_next  = head.cmd.lo;
            q_hi_next  = head.cmd.hi;
            state_next = ST_RANGE;
          end
        end
      end
      ST_RANGE: begin
        if (!rv_q || (sbii_pkg::cnt_t'(rs_q) >= re_q)) begin
          result_valid_next = 1'b1;
          out_last_next     = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          cur_next        = rs_q;
          end_q_next      = re_q;
          n_hits_next     = '0;
          pend_valid_next = 1'b0;
          state_next      = ST_WALK;
        end
      end
      ST_WALK: begin
        // a hit is held back one step so the final one can carry last
        if (overlap) begin
          if (pend_valid) begin
            result_valid_next = 1'b1;
            out_idx_next      = pend_idx;
            out_hit_next      = 1'b1;
          end
          pend_valid_next = 1'b1;
          pend_idx_next   = cur;
          n_hits_next     = n_hits + 1'b1;
        end
        if (stop) begin
          state_next = ST_DONE;
        end else begin
          cur_next = sbii_pkg::idx_t'(cur_inc);
        end
      end
      ST_DONE: begin
        result_valid_next = 1'b1;
        out_last_next     = 1'b1;
        if (pend_valid) begin
          out_idx_next = pend_idx;
          out_hit_next = 1'b1;
        end
        pend_valid_next = 1'b0;
        state_next      = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      block_count  <= '0;
      prev_contig  <= '0;
      range_valid  <= '0;
      result_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      block_count  <= block_count_next;
      prev_contig  <= prev_contig_next;
      range_valid  <= range_valid_next;
      result_valid <= result_valid_next;
      pend_valid   <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_idx  <= out_idx_next;
    out_hit  <= out_hit_next;
    out_full <= out_full_next;
    out_last <= out_last_next;
    q_lo     <= q_lo_next;
    q_hi     <= q_hi_next;
    cur      <= cur_next;
    end_q    <= end_q_next;
    n_hits   <= n_hits_next;
    pend_idx <= pend_idx_next;
  end

  assign block_index = 6'(out_idx);
  assign hit         = out_hit;
  assign table_full  = out_full;
  assign last        = out_last;

`ifndef SYNTH
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    result_valid && table_full |-> !hit && last)
    else $error("refused load word must carry no hit and last");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    block_count <= sbii_pkg::cnt_t'(sbii_pkg::MAX_BLOCKS))
    else $error("block count past table size");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> result_valid && last)
    else $error("end of walk must give a last word");

  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_RANGE) || result_valid)
    else $error("popped word neither answered nor looked up");
`endif

endmodule

// ===== src/sorted_block_interval_index.sv =====
// Top level of the sorted block interval index: front queue plus back end.
// Depends on sbii_pkg, sbii_front and sbii_back.
//
//  channel  | handshake                  | ports
//  ---------+----------------------------+------------------------------------------
//  request  | start && !busy             | req_type contig_id span_low span_high
//  result   | result_valid, one cycle    | block_index hit table_full last
//
// A load answers in the cycle after it leaves the queue.
// A query reads the range table, walks its blocks in order from the block table, then flushes
// the last hit. A query whose range is empty walks no block.
// The two-word queue keeps accepting while the back end walks; busy rises when it is full.
// Reset (rst, synchronous) empties the queue, the block count and all contig ranges.
// Results cannot be held off by the receiver.
module sorted_block_interval_index (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [7:0]  contig_id,
  input  logic [31:0] span_low,
  input  logic [31:0] span_high,
  output logic        result_valid,
  output logic [5:0]  block_index,
  output logic        hit,
  output logic        table_full,
  output logic        last
);

  sbii_pkg::queue_head_t head;
  logic                  pop;

  sbii_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .contig_id (contig_id),
    .span_low  (span_low),
    .span_high (span_high),
    .head      (head),
    .pop       (pop)
  );

  sbii_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .block_index  (block_index),
    .hit          (hit),
    .table_full   (table_full),
    .last         (last)
  );

endmodule

// ===== tb/tb_sorted_block_interval_index.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for sorted_block_interval_index: block loads and overlap queries.
// Needs sbii_pkg and the RTL of the block; predicts every result word in order and compares.
module tb_sorted_block_interval_index;

  typedef struct {
    logic              req;
    sbii_pkg::contig_t contig;
    sbii_pkg::pos_t    lo;
    sbii_pkg::pos_t    hi;
  } index_word_t;

  typedef struct {
    logic [5:0] idx;
    logic       hit;
    logic       full;
    logic       last;
  } hit_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        req_type = 1'b0;
  logic [7:0]  contig_id = 8'd0;
  logic [31:0] span_low = 32'd0;
  logic [31:0] span_high = 32'd0;
  logic        busy;
  logic        result_valid;
  logic [5:0]  block_index;
  logic        hit;
  logic        table_full;
  logic        last;

  sorted_block_interval_index u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .contig_id    (contig_id),
    .span_low     (span_low),
    .span_high    (span_high),
    .result_valid (result_valid),
    .block_index  (block_index),
    .hit          (hit),
    .table_full   (table_full),
    .last         (last)
  );

  always #1 clk = ~clk;

  // words waiting to be sent, and result words the index should produce
  index_word_t stim_q[$];
  hit_word_t   block_hits_q[$];

  // shadow of the index state
  sbii_pkg::contig_t blk_contig [sbii_pkg::MAX_BLOCKS];
  sbii_pkg::pos_t    blk_low    [sbii_pkg::MAX_BLOCKS];
  sbii_pkg::pos_t    blk_high   [sbii_pkg::MAX_BLOCKS];
  int                blk_count = 0;
  sbii_pkg::contig_t prev_contig = '0;
  int                run_first [sbii_pkg::MAX_CONTIGS];
  int                run_end   [sbii_pkg::MAX_CONTIGS];

  // what the stimulus generator has loaded so far, used to aim queries
  sbii_pkg::contig_t gen_contig [sbii_pkg::MAX_BLOCKS];
  sbii_pkg::pos_t    gen_lo     [sbii_pkg::MAX_BLOCKS];
  sbii_pkg::pos_t    gen_hi     [sbii_pkg::MAX_BLOCKS];
  int                gen_loads = 0;

  int words_queued = 0;
  int loads_done = 0;
  int loads_refused = 0;
  int queries_done = 0;
  int words_checked = 0;
  int error_count = 0;

  index_word_t cur_word;
  int          gap_left = 0;
  logic        no_idle = 1'b0;

  initial begin
    for (int k = 0; k < sbii_pkg::MAX_CONTIGS; k++) begin
      run_first[k] = 0;
      run_end[k]   = 0;
    end
  end

  function automatic sbii_pkg::pos_t sat_add(sbii_pkg::pos_t a, sbii_pkg::pos_t b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic sbii_pkg::pos_t sat_sub(sbii_pkg::pos_t a, sbii_pkg::pos_t b);
    return (b > a) ? 32'd0 : a - b;
  endfunction

  task automatic add_word(logic req, sbii_pkg::contig_t c, sbii_pkg::pos_t lo,
                          sbii_pkg::pos_t hi);
    index_word_t w;
    w.req    = req;
    w.contig = c;
    w.lo     = lo;
    w.hi     = hi;
    stim_q = {stim_q, w};
    words_queued++;
    if (req == sbii_pkg::REQ_LOAD && gen_loads < sbii_pkg::MAX_BLOCKS) begin
      gen_contig[gen_loads] = c;
      gen_lo[gen_loads]     = lo;
      gen_hi[gen_loads]     = hi;
      gen_loads++;
    end
  endtask

  // applies one accepted word to the shadow state and queues its result words
  task automatic compute_block_hits(index_word_t w);
    hit_word_t r;
    hit_word_t pend;
    logic      have_pend;
    logic      walking;
    int        slot;
    int        i;
    int        stop;
    int        n;
    slot = int'(w.contig) % sbii_pkg::MAX_CONTIGS;
    if (w.req == sbii_pkg::REQ_LOAD) begin
      if (blk_count >= sbii_pkg::MAX_BLOCKS) begin
        r = '{idx: 6'd0, hit: 1'b0, full: 1'b1, last: 1'b1};
        loads_refused++;
      end else begin
        blk_contig[blk_count] = w.contig;
        blk_low[blk_count]    = w.lo;
        blk_high[blk_count]   = w.hi;
        if (blk_count == 0 || w.contig != prev_contig) begin
          run_first[slot] = blk_count;
        end
        run_end[slot] = blk_count + 1;
        prev_contig   = w.contig;
        r = '{idx: 6'(blk_count), hit: 1'b1, full: 1'b0, last: 1'b1};
        blk_count++;
      end
      loads_done++;
      block_hits_q = {block_hits_q, r};
    end else begin
      queries_done++;
      stop = (run_end[slot] > blk_count) ? blk_count : run_end[slot];
      n = 0;
      have_pend = 1'b0;
      walking = 1'b1;
      for (i = run_first[slot]; walking && i < stop && n < sbii_pkg::RESULT_CAP; i++) begin
        if ((w.lo >= blk_low[i] && w.lo <= blk_high[i]) ||
            (w.hi >= blk_low[i] && w.hi <= blk_high[i]) ||
            (w.lo <= blk_low[i] && w.hi >= blk_high[i])) begin
          if (have_pend) block_hits_q = {block_hits_q, pend};
          pend = '{idx: 6'(i), hit: 1'b1, full: 1'b0, last: 1'b0};
          have_pend = 1'b1;
          n++;
        end
        // sorted by min: nothing later can overlap
        if (blk_low[i] > w.hi) walking = 1'b0;
      end
      if (have_pend) begin
        pend.last = 1'b1;
        block_hits_q = {block_hits_q, pend};
      end else begin
        r = '{idx: 6'd0, hit: 1'b0, full: 1'b0, last: 1'b1};
        block_hits_q = {block_hits_q, r};
      end
    end
  endtask

  always @(posedge clk) begin : driver
    logic start_n;
    int   r;
    start_n = start;
    if (rst) begin
      start_n  = 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        compute_block_hits(cur_word);
        start_n = 1'b0;
      end
      if (!start_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() != 0) begin
          cur_word  = stim_q.pop_front();
          req_type  <= cur_word.req;
          contig_id <= cur_word.contig;
          span_low  <= cur_word.lo;
          span_high <= cur_word.hi;
          start_n   = 1'b1;
          if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
          r = $urandom_range(0, 99);
          if (no_idle || r < 60) begin
            gap_left = 0;
          end else if (r < 92) begin
            gap_left = $urandom_range(1, 3);
          end else begin
            gap_left = $urandom_range(10, 60);
          end
        end
      end
    end
    start <= start_n;
  end

  always @(posedge clk) begin : monitor
    hit_word_t e;
    if (!rst && result_valid) begin
      words_checked++;
      if (block_hits_q.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result word at %0t: idx %0d hit %0b full %0b last %0b",
                   $time, block_index, hit, table_full, last);
        end
      end else begin
        e = block_hits_q.pop_front();
        if (block_index !== e.idx || hit !== e.hit || table_full !== e.full ||
            last !== e.last) begin
          error_count++;
          if (error_count <= 10) begin
            $write("mismatch at %0t: exp idx %0d hit %0b full %0b last %0b, ",
                   $time, e.idx, e.hit, e.full, e.last);
            $display("got idx %0d hit %0b full %0b last %0b",
                     block_index, hit, table_full, last);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int                n;
    int                j;
    int                mode;
    int                run_left;
    sbii_pkg::contig_t run_contig;
    sbii_pkg::pos_t    run_pos;
    sbii_pkg::pos_t    lo;
    sbii_pkg::pos_t    hi;
    sbii_pkg::pos_t    mn;
    sbii_pkg::pos_t    mx;

    // query before anything is loaded: empty range
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd0, 32'hFFFF_FFFF);
    // first load opens a range even though contig 0 equals the reset contig
    add_word(sbii_pkg::REQ_LOAD, 8'd0, 32'd0, 32'd0);
    add_word(sbii_pkg::REQ_LOAD, 8'd0, 32'd10, 32'd20);
    add_word(sbii_pkg::REQ_LOAD, 8'd0, 32'd30, 32'hFFFF_FFFF);
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd0, 32'hFFFF_FFFF);
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd15, 32'd15);
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd25, 32'd28);
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd20, 32'd30);
    add_word(sbii_pkg::REQ_LOAD, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_word(sbii_pkg::REQ_QUERY, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // contig 0 comes back: its range reopens, older blocks drop out of reach
    add_word(sbii_pkg::REQ_LOAD, 8'd0, 32'd100, 32'd200);
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd0, 32'hFFFF_FFFF);
    add_word(sbii_pkg::REQ_QUERY, 8'd7, 32'd0, 32'hFFFF_FFFF);
    // inverted interval
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd300, 32'd50);
    add_word(sbii_pkg::REQ_LOAD, 8'd0, 32'd150, 32'd160);
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd155, 32'd155);
    add_word(sbii_pkg::REQ_QUERY, 8'd0, 32'd160, 32'd99);
    add_word(sbii_pkg::REQ_QUERY, 8'd255, 32'd0, 32'hFFFF_FFFE);

    run_left   = 0;
    run_contig = '0;
    run_pos    = '0;
    for (n = 0; n < 450; n++) begin
      if ((gen_loads < sbii_pkg::MAX_BLOCKS && $urandom_range(0, 4) == 0) ||
          (gen_loads >= sbii_pkg::MAX_BLOCKS && $urandom_range(0, 19) == 0)) begin
        if ($urandom_range(0, 9) == 0) begin
          add_word(sbii_pkg::REQ_LOAD, sbii_pkg::contig_t'($urandom_range(0, 255)),
                   $urandom, $urandom);
        end else begin
          if (run_left == 0) begin
            if (gen_loads > 0 && $urandom_range(0, 3) == 0) begin
              run_contig = gen_contig[$urandom_range(0, gen_loads - 1)];
            end else begin
              run_contig = sbii_pkg::contig_t'($urandom_range(0, 255));
            end
            run_left = $urandom_range(1, 8);
            run_pos  = ($urandom_range(0, 4) == 0) ?
                       sbii_pkg::pos_t'($urandom) :
                       sbii_pkg::pos_t'($urandom_range(0, 32'h00FF_FFFF));
          end
          lo = sat_add(run_pos, $urandom_range(0, 40));
          hi = sat_add(lo, $urandom_range(0, 100));
          run_pos = lo;
          run_left--;
          add_word(sbii_pkg::REQ_LOAD, run_contig, lo, hi);
        end
      end else if (gen_loads > 0 && $urandom_range(0, 3) != 0) begin
        j    = $urandom_range(0, gen_loads - 1);
        mn   = gen_lo[j];
        mx   = gen_hi[j];
        mode = $urandom_range(0, 3);
        case (mode)
          0: begin
            lo = (mx >= mn) ? mn + $urandom_range(0, mx - mn) : mn;
            hi = lo;
          end
          1: begin
            lo = sat_sub(mn, $urandom_range(0, 500));
            hi = sat_add(mx, $urandom_range(0, 500));
          end
          2: begin
            lo = sat_sub(mn, $urandom_range(0, 30));
            hi = sat_add(lo, $urandom_range(0, 80));
          end
          default: begin
            lo = 32'd0;
            hi = 32'hFFFF_FFFF;
          end
        endcase
        add_word(sbii_pkg::REQ_QUERY, gen_contig[j], lo, hi);
      end else begin
        add_word(sbii_pkg::REQ_QUERY, sbii_pkg::contig_t'($urandom_range(0, 255)),
                 $urandom, $urandom);
      end
    end
  end

  initial begin : run_control
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (loads_done + queries_done < words_queued) @(posedge clk);
    while (block_hits_q.size() != 0) @(posedge clk);
    // the longest walk covers the whole table
    repeat (sbii_pkg::MAX_BLOCKS + 16) @(posedge clk);
    $display("run covered %0d loads (%0d refused on a full table) and %0d queries",
             loads_done, loads_refused, queries_done);
    $display("%0d result words compared, %0d errors", words_checked, error_count);
    if (error_count == 0 && block_hits_q.size() == 0) begin
      $display("sorted_block_interval_index verification clean");
    end else begin
      $display("sorted_block_interval_index verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("timeout: %0d result words still outstanding", block_hits_q.size());
    $display("sorted_block_interval_index verification failed");
    $finish;
  end

endmodule
